[sv/normal_map_from_height_map_assert.svh]
// Assertion macros for the height-to-normal block checker.
// Plain header, no dependencies; included by the checker file.
`ifndef NORMAL_MAP_FROM_HEIGHT_MAP_ASSERT_SVH
`define NORMAL_MAP_FROM_HEIGHT_MAP_ASSERT_SVH

// same-cycle implication
`define NMH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NMH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/nmh_pkg.sv]
// Shared constants, types and control structs of the height-to-normal block.
// No dependencies; imported by every module of the block.
package nmh_pkg;

   localparam int MAX_COLUMNS = 512;
   localparam int MAX_ROWS    = 512;
   localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int POS_W    = 9;    // column / row field width
   localparam int SIZE_W   = 10;   // image size register width
   localparam int SCALE_W  = 24;
   localparam int SAMPLE_W = 16;
   localparam int GRAD_W   = 24;   // gradient magnitude, up to 2^23
   localparam int SUM_W    = 48;   // gu^2 + gv^2 + 2^32
   localparam int QUOT_W   = 61;   // floor(2^92 / S)
   localparam int ROOT_W   = 31;   // floor(2^46 / sqrt(S))
   localparam int DIV_STEPS  = 93; // one quotient bit per cycle, bits 92..0
   localparam int SQRT_STEPS = 31; // two radicand bits per cycle
   localparam int CNT_W    = 7;
   localparam int STEP_W   = 3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_HEIGHT_SCALE,
      CSR_WRAP_COLUMNS,
      CSR_WRAP_ROWS
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_ROOT,
      ST_NORM,
      ST_OUT
   } nmh_state_type;

   typedef enum logic [1:0] {
      RQ_IDLE,
      RQ_DIV,
      RQ_SQRT,
      RQ_DONE
   } rsq_state_type;

   typedef struct packed {
      logic [POS_W-1:0] a;
      logic [POS_W-1:0] b;
      logic             halved;
   } pick_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] sum;
   } rsq_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } rsq_stat_type;

endpackage

[sv/nmh_rsqrt.sv]
// Iterative reciprocal square root: floor(2^46/sqrt(S)) as isqrt(floor(2^92/S)).
// Restoring divider then digit-by-digit square root; uses nmh_pkg.
module nmh_rsqrt
   import nmh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsq_ctrl_type ctrl,
   output rsq_stat_type stat
);

   rsq_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SUM_W-1:0]  s_ff;
   logic [SUM_W-1:0]  r_ff;
   logic [QUOT_W-1:0] v_ff;
   logic [QUOT_W:0]   res_ff;
   logic [QUOT_W-1:0] bit_ff;

   logic [SUM_W:0]  r_sh;
   logic            ge;
   logic [QUOT_W:0] trial;
   logic            fits;

   assign r_sh  = {r_ff, (cnt_ff == '0)};   // dividend is a lone one at bit 92
   assign ge    = (r_sh >= {1'b0, s_ff});
   assign trial = res_ff + {1'b0, bit_ff};
   assign fits  = ({1'b0, v_ff} >= trial);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RQ_IDLE: if (ctrl.start) state_in = RQ_DIV;
         RQ_DIV:  if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = RQ_SQRT;
         RQ_SQRT: if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = RQ_DONE;
         RQ_DONE: state_in = RQ_IDLE;
         default: state_in = RQ_IDLE;
      endcase
   end

   always_comb begin
      stat.done = (state_ff == RQ_DONE);
      stat.root = res_ff[ROOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         RQ_IDLE: begin
            cnt_ff <= '0;
            if (ctrl.start) begin
               s_ff <= ctrl.sum;
               r_ff <= '0;
               v_ff <= '0;
            end
         end
         RQ_DIV: begin
            r_ff <= SUM_W'(ge ? (r_sh - {1'b0, s_ff}) : r_sh);
            v_ff <= {v_ff[QUOT_W-2:0], ge};
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_ff <= '0;
               res_ff <= '0;
               bit_ff <= QUOT_W'(1) << (QUOT_W - 1);
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         RQ_SQRT: begin
            if (fits) begin
               v_ff   <= QUOT_W'({1'b0, v_ff} - trial);
               res_ff <= (res_ff >> 1) + {1'b0, bit_ff};
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 1'b1;
         end
         RQ_DONE: cnt_ff <= '0;
         default: cnt_ff <= '0;
      endcase
   end

endmodule

[sv/normal_map_from_height_map.sv]
// Height map to normal map. Write requests store one 16-bit height sample at
// (column,row) in an internal MAX_COLUMNS x MAX_ROWS sample memory; the block
// is ready again right after. A query request reads the four neighbors of the
// pixel through one memory port, forms both halved central differences
// (one-sided at edges unless wrapping is on), scales them through one shared
// 32x32 multiplier, then a bit-serial unit computes 1/sqrt(gu^2+gv^2+1) with a
// restoring divider and a square root; the multiplier then forms the x and y
// components. The divider loop dominates a query. The block is ready for the
// next request in the same cycle that the result appears. A result still
// waiting in the output register holds the query that follows it in its output
// state until that result is taken. The result sits in an output register, so
// the next request is taken while it waits.
// The sample memory is not cleared: query only pixels whose neighbors were written.
// Uses nmh_pkg and nmh_rsqrt.
module normal_map_from_height_map
   import nmh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // column[8:0], row[17:9], height_sample[33:18]
   input  logic [0:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // normal_x[15:0], normal_y[31:16], normal_z[46:32]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   // request fields
   logic [POS_W-1:0]    req_column;
   logic [POS_W-1:0]    req_row;
   logic [SAMPLE_W-1:0] req_height;
   logic                req_cmd;

   assign req_column = req_tdata[8:0];
   assign req_row    = req_tdata[17:9];
   assign req_height = req_tdata[33:18];
   assign req_cmd    = req_tuser[0];

   // configuration
   logic [SIZE_W-1:0]  width_ff, height_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic               wrapc_ff, wrapr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(512);
         height_ff <= SIZE_W'(512);
         scale_ff  <= SCALE_W'(65536);
         wrapc_ff  <= 1'b0;
         wrapr_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT_SCALE: scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_WRAP_COLUMNS: wrapc_ff  <= csr_wdata[0];
            CSR_WRAP_ROWS:    wrapr_ff  <= csr_wdata[0];
            default: ;   // unmapped index: ignored
         endcase
      end
   end

   // neighbor selection for one axis
   function automatic pick_type pick(input logic [POS_W-1:0] p,
                                     input logic [SIZE_W-1:0] n,
                                     input logic wrap);
      pick_type pk;
      logic [POS_W-1:0] last;
      last = POS_W'(n - 1'b1);
      if (p != '0 && p < last) begin
         pk.a = p + 1'b1;
         pk.b = p - 1'b1;
         pk.halved = 1'b1;
      end else if (p == '0) begin
         pk.a = POS_W'(1);
         pk.b = wrap ? last : '0;
         pk.halved = wrap;
      end else begin
         pk.a = wrap ? '0 : last;
         pk.b = last - 1'b1;
         pk.halved = wrap;
      end
      return pk;
   endfunction

   // rounded, saturated Q8.16 gradient magnitude from |d|*W*scale
   function automatic logic [GRAD_W-1:0] grad_mag(input logic [63:0] p,
                                                 input logic halved,
                                                 input logic neg);
      logic [63:0] rnd;
      logic [63:0] lim;
      rnd = halved ? ((p + 64'd65536) >> 17) : ((p + 64'd32768) >> 16);
      lim = neg ? 64'd8388608 : 64'd8388607;
      return (rnd > lim) ? lim[GRAD_W-1:0] : rnd[GRAD_W-1:0];
   endfunction

   // Q1.15 component, sign opposite to the gradient
   function automatic logic [15:0] component(input logic [63:0] p, input logic neg);
      logic [63:0] m;
      logic [15:0] c;
      m = p >> 31;
      c = (m > 64'd32767) ? 16'd32767 : m[15:0];
      return neg ? c : 16'(-c);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] c,
                                                input logic [POS_W-1:0] r);
      return ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
   endfunction

   // clamped image size and query position
   logic [SIZE_W-1:0] w_lim, h_lim;
   logic [POS_W-1:0]  col_c, row_c;
   pick_type          pk_u, pk_v;
   logic              wr_in_range;

   always_comb begin
      w_lim = (width_ff < SIZE_W'(2)) ? SIZE_W'(2) :
              ((int'(width_ff) > MAX_COLUMNS) ? SIZE_W'(MAX_COLUMNS) : width_ff);
      h_lim = (height_ff < SIZE_W'(2)) ? SIZE_W'(2) :
              ((int'(height_ff) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : height_ff);
      col_c = ({1'b0, req_column} > w_lim - 1'b1) ? POS_W'(w_lim - 1'b1) : req_column;
      row_c = ({1'b0, req_row} > h_lim - 1'b1) ? POS_W'(h_lim - 1'b1) : req_row;
      pk_u  = pick(col_c, w_lim, wrapc_ff);
      pk_v  = pick(row_c, h_lim, wrapr_ff);
      wr_in_range = (int'(req_column) < MAX_COLUMNS) && (int'(req_row) < MAX_ROWS);
   end

   // sequencer
   nmh_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   rsq_ctrl_type rsq_ctrl;
   rsq_stat_type rsq_stat;
   logic         rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid && req_cmd == CMD_QUERY) state_in = ST_READ;
         ST_READ: if (step_ff == STEP_W'(4)) state_in = ST_GRAD;
         ST_GRAD: if (step_ff == STEP_W'(6)) state_in = ST_ROOT;
         ST_ROOT: if (rsq_stat.done) state_in = ST_NORM;
         ST_NORM: if (step_ff == STEP_W'(2)) state_in = ST_OUT;
         ST_OUT:  if (!rsp_tvalid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      step_in = (state_in != state_ff) ? '0 : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // query context, taken at acceptance
   logic [POS_W-1:0]  colq_ff, rowq_ff, au_ff, bu_ff, av_ff, bv_ff;
   logic              hu_ff, hv_ff;
   logic [SIZE_W-1:0] wq_ff, hq_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept) begin
         colq_ff <= col_c;
         rowq_ff <= row_c;
         au_ff   <= pk_u.a;
         bu_ff   <= pk_u.b;
         hu_ff   <= pk_u.halved;
         av_ff   <= pk_v.a;
         bv_ff   <= pk_v.b;
         hv_ff   <= pk_v.halved;
         wq_ff   <= w_lim;
         hq_ff   <= h_lim;
      end
   end

   // sample memory: one port, writes while idle, reads during READ
   logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] mem_q_ff;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_we;

   logic [63:0]         mul_ff;
   logic [31:0]         mul_a, mul_b;
   logic                rsp_load;

   // neighbor samples: right, left, below, above (in the order read)
   logic [SAMPLE_W-1:0] nb_ff [4];
   logic [SAMPLE_W:0]   du, dv;
   logic                negu, negv;
   logic [SAMPLE_W-1:0] magu, magv;
   logic [GRAD_W-1:0]   gmu_ff, gmv_ff;
   logic                negu_ff, negv_ff;
   logic [46:0]         sq_ff;   // gu^2, up to 2^46

   always_comb begin
      du   = {1'b0, nb_ff[0]} - {1'b0, nb_ff[1]};
      dv   = {1'b0, nb_ff[2]} - {1'b0, nb_ff[3]};
      negu = du[SAMPLE_W];
      negv = dv[SAMPLE_W];
      magu = negu ? SAMPLE_W'(-du) : du[SAMPLE_W-1:0];
      magv = negv ? SAMPLE_W'(-dv) : dv[SAMPLE_W-1:0];
   end

   // outputs of the sequencer: memory port, multiplier operands, handshakes
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      mem_we     = (state_ff == ST_IDLE) && req_accept && req_cmd == CMD_WRITE
                   && wr_in_range;
      mem_addr   = addr_of(req_column, req_row);
      mul_a      = '0;
      mul_b      = '0;
      rsq_ctrl.start = 1'b0;
      rsq_ctrl.sum   = SUM_W'(sq_ff) + SUM_W'(mul_ff[46:0]) + (SUM_W'(1) << 32);
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_READ: begin
            unique case (step_ff)
               STEP_W'(0): mem_addr = addr_of(au_ff, rowq_ff);
               STEP_W'(1): mem_addr = addr_of(bu_ff, rowq_ff);
               STEP_W'(2): mem_addr = addr_of(colq_ff, av_ff);
               default:    mem_addr = addr_of(colq_ff, bv_ff);
            endcase
         end
         ST_GRAD: begin
            unique case (step_ff)
               STEP_W'(0): begin mul_a = 32'(magu);        mul_b = 32'(wq_ff);    end
               STEP_W'(1): begin mul_a = mul_ff[31:0];     mul_b = 32'(scale_ff); end
               STEP_W'(2): begin mul_a = 32'(magv);        mul_b = 32'(hq_ff);    end
               STEP_W'(3): begin mul_a = mul_ff[31:0];     mul_b = 32'(scale_ff); end
               STEP_W'(4): begin mul_a = 32'(gmu_ff);      mul_b = 32'(gmu_ff);   end
               STEP_W'(5): begin mul_a = 32'(gmv_ff);      mul_b = 32'(gmv_ff);   end
               default:    rsq_ctrl.start = 1'b1;
            endcase
         end
         ST_ROOT: ;
         ST_NORM: begin
            unique case (step_ff)
               STEP_W'(0): begin mul_a = 32'(gmu_ff); mul_b = 32'(rsq_stat.root); end
               STEP_W'(1): begin mul_a = 32'(gmv_ff); mul_b = 32'(rsq_stat.root); end
               default: ;
            endcase
         end
         ST_OUT:  rsp_load = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= req_height;
      end
      mem_q_ff <= store_mem[mem_addr];
   end

   // shared multiplier, registered
   always_ff @(posedge clock) begin
      mul_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // read data is registered: it arrives in the cycle after its address
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ && step_ff != '0) begin
         nb_ff[2'(step_ff - 1'b1)] <= mem_q_ff;
      end
   end

   // gradients and squares
   always_ff @(posedge clock) begin
      if (state_ff == ST_GRAD) begin
         if (step_ff == STEP_W'(2)) begin
            gmu_ff  <= grad_mag(mul_ff, hu_ff, negu);
            negu_ff <= negu;
         end
         if (step_ff == STEP_W'(4)) begin
            gmv_ff  <= grad_mag(mul_ff, hv_ff, negv);
            negv_ff <= negv;
         end
         if (step_ff == STEP_W'(5)) begin
            sq_ff <= mul_ff[46:0];
         end
      end
   end

   nmh_rsqrt u_rsqrt (
      .clock (clock),
      .reset (reset),
      .ctrl  (rsq_ctrl),
      .stat  (rsq_stat)
   );

   // normal components
   logic [15:0] nx_ff, ny_ff;
   logic [14:0] nz_ff;
   logic [15:0] rz;

   assign rz = 16'(rsq_stat.root >> 15);

   always_ff @(posedge clock) begin
      if (state_ff == ST_NORM) begin
         if (step_ff == STEP_W'(1)) begin
            nx_ff <= component(mul_ff, negu_ff);
         end
         if (step_ff == STEP_W'(2)) begin
            ny_ff <= component(mul_ff, negv_ff);
            nz_ff <= (rz > 16'd32767) ? 15'd32767 : rz[14:0];   // flat surface saturates
         end
      end
   end

   // output register
   logic [47:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, nz_ff, ny_ff, nx_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sv/nmh_checker.sv]
// Port-level checker for the height-to-normal block, bound to the top level.
// Uses nmh_pkg and the assertion macro header.
`include "normal_map_from_height_map_assert.svh"

module nmh_checker
   import nmh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   `NMH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `NMH_ASSERT_NEXT(a_query_busy, clock, reset, req_tvalid && req_tready && req_tuser[0] == CMD_QUERY, !req_tready, "ready after query request")
   `NMH_ASSERT_NEXT(a_write_ready, clock, reset, req_tvalid && req_tready && req_tuser[0] == CMD_WRITE, req_tready, "busy after write request")
   `NMH_ASSERT_NOW(a_result_from_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready), "result appeared while idle")

endmodule

bind normal_map_from_height_map nmh_checker u_checker (.*);

[test/normal_map_from_height_map_test.sv]
// Testbench for normal_map_from_height_map: height writes and normal queries
// checked against a scoreboard that keeps its own copy of the height image.
// Depends on nmh_pkg and the block's RTL only.
`timescale 1ns / 100ps

module normal_map_from_height_map_test;
   import nmh_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 1150;

   typedef struct packed {
      logic [15:0] nx;
      logic [15:0] ny;
      logic [14:0] nz;
   } normal_type;

   // Height image shadow, config shadow and expected normals in order.
   class normal_scoreboard;
      bit [15:0]   heights[MAX_COLUMNS * MAX_ROWS];
      bit          written[MAX_COLUMNS * MAX_ROWS];
      bit [9:0]    width_reg = 512;
      bit [9:0]    height_reg = 512;
      bit [23:0]   scale = 65536;
      bit          wrap_c = 0;
      bit          wrap_r = 0;
      normal_type  expected_normals[$];
      int          errors = 0;

      function int unsigned image_w();
         return (width_reg < 2) ? 2 : (width_reg > MAX_COLUMNS) ? MAX_COLUMNS : width_reg;
      endfunction

      function int unsigned image_h();
         return (height_reg < 2) ? 2 : (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
      endfunction

      function bit is_written(int unsigned c, int unsigned r);
         return written[r * MAX_COLUMNS + c];
      endfunction

      // neighbor pair along one axis, halved or one-sided at edges
      function void neighbors(int unsigned p, int unsigned n, bit wrap,
                              output int unsigned a, output int unsigned b,
                              output bit halved);
         if (p > 0 && p < n - 1) begin
            a = p + 1; b = p - 1; halved = 1;
         end else if (p == 0) begin
            a = 1; b = wrap ? n - 1 : 0; halved = wrap;
         end else begin
            a = wrap ? 0 : n - 1; b = n - 2; halved = wrap;
         end
      endfunction

      // the four samples a query at (col,row) reads, as column/row pairs
      function void query_taps(int unsigned col, int unsigned row,
                               output int unsigned tc[4], output int unsigned tr[4]);
         int unsigned a, b;
         bit h;
         if (col > image_w() - 1) col = image_w() - 1;
         if (row > image_h() - 1) row = image_h() - 1;
         neighbors(col, image_w(), wrap_c, a, b, h);
         tc[0] = a; tr[0] = row; tc[1] = b; tr[1] = row;
         neighbors(row, image_h(), wrap_r, a, b, h);
         tc[2] = col; tr[2] = a; tc[3] = col; tr[3] = b;
      endfunction

      function longint scaled_slope(longint d, bit halved, int unsigned size);
         longint unsigned mag;
         int unsigned sh;
         sh = halved ? 17 : 16;
         mag = (d < 0) ? -d : d;
         mag = mag * scale * size;
         mag = (mag + (64'd1 << (sh - 1))) >> sh;
         if (d < 0) return (mag > 8388608) ? -64'sd8388608 : -longint'(mag);
         return (mag > 8388607) ? 8388607 : longint'(mag);
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, bt;
         res = 0;
         bt = 64'd1 << 62;
         while (bt > v) bt >>= 2;
         while (bt != 0) begin
            if (v >= res + bt) begin
               v -= res + bt;
               res = (res >> 1) + bt;
            end else res >>= 1;
            bt >>= 2;
         end
         return res;
      endfunction

      function bit [15:0] tilt(longint g, longint unsigned root);
         bit [127:0] prod;
         bit [15:0] mag;
         prod = 128'((g < 0) ? -g : g) * 128'(root);
         prod = prod >> 31;
         mag = (prod > 32767) ? 16'd32767 : prod[15:0];
         return (g < 0) ? mag : -mag;   // points away from the slope
      endfunction

      function void note_request(bit cmd, int unsigned col, int unsigned row,
                                 bit [15:0] sample);
         int unsigned a, b, w, h;
         bit halved;
         longint gu, gv;
         longint unsigned sum, root;
         bit [127:0] quot;
         normal_type n;
         if (cmd == CMD_WRITE) begin
            heights[row * MAX_COLUMNS + col] = sample;
            written[row * MAX_COLUMNS + col] = 1;
            return;
         end
         w = image_w();
         h = image_h();
         if (col > w - 1) col = w - 1;
         if (row > h - 1) row = h - 1;
         neighbors(col, w, wrap_c, a, b, halved);
         gu = scaled_slope(longint'(heights[row * MAX_COLUMNS + a]) -
                           longint'(heights[row * MAX_COLUMNS + b]), halved, w);
         neighbors(row, h, wrap_r, a, b, halved);
         gv = scaled_slope(longint'(heights[a * MAX_COLUMNS + col]) -
                           longint'(heights[b * MAX_COLUMNS + col]), halved, h);
         sum = gu * gu + gv * gv + (64'd1 << 32);
         quot = (128'd1 << 92) / 128'(sum);
         root = int_sqrt(quot[63:0]);
         n.nx = tilt(gu, root);
         n.ny = tilt(gv, root);
         n.nz = ((root >> 15) > 32767) ? 15'd32767 : 15'(root >> 15);
         expected_normals.push_back(n);
      endfunction

      function void check_response(logic [47:0] data);
         normal_type e;
         if (expected_normals.size() == 0) begin
            $display("%0t: unexpected normal %h", $time, data);
            errors++;
            return;
         end
         e = expected_normals.pop_front();
         if (data[15:0] !== e.nx) begin
            $display("%0t: normal_x expected %h actual %h", $time, e.nx, data[15:0]);
            errors++;
         end
         if (data[31:16] !== e.ny) begin
            $display("%0t: normal_y expected %h actual %h", $time, e.ny, data[31:16]);
            errors++;
         end
         if (data[46:32] !== e.nz) begin
            $display("%0t: normal_z expected %h actual %h", $time, e.nz, data[46:32]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // column[8:0], row[17:9], height_sample[33:18]
   logic [0:0]  req_tuser = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;        // normal_x[15:0], normal_y[31:16], normal_z[46:32]
   logic        csr_we = 0;
   logic [2:0]  csr_addr = '0;
   logic [23:0] csr_wdata = '0;

   normal_scoreboard normals = new();
   bit  calm = 0;          // when set, neither side idles
   int  cycles = 0;
   int  sent = 0;

   normal_map_from_height_map u_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
   end

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Handshakes are sampled mid-cycle, where every signal is settled; the
   // transfer itself happens at the next rising edge.
   always @(negedge clock) begin
      if (!reset && req_tvalid && req_tready)
         normals.note_request(req_tuser[0], req_tdata[8:0], req_tdata[17:9],
                              req_tdata[33:18]);
      if (!reset && rsp_tvalid && rsp_tready)
         normals.check_response(rsp_tdata);
   end

   function int draw_gap();
      return calm ? 0 : $urandom_range(0, 6);
   endfunction

   // Receiver: stall before each normal for a gap drawn by draw_gap.
   initial begin
      int  gap;
      bit  taken;
      @(negedge reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do begin
            @(negedge clock);
            taken = rsp_tvalid;
            @(posedge clock);
         end while (!taken);
      end
   end

   // One request. tvalid stays high between back-to-back requests.
   task automatic send_request(bit cmd, bit [8:0] col, bit [8:0] row, bit [15:0] sample);
      int gap;
      bit taken;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {6'b0, sample, row, col};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      sent++;
      if ($urandom_range(0, 49) == 0) calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic write_height(bit [8:0] col, bit [8:0] row, bit [15:0] sample);
      send_request(CMD_WRITE, col, row, sample);
   endtask

   // Fill any unwritten sample the query reads, then issue the query.
   task automatic query_normal(bit [8:0] col, bit [8:0] row);
      int unsigned tc[4], tr[4];
      normals.query_taps(col, row, tc, tr);
      for (int i = 0; i < 4; i++)
         if (!normals.is_written(tc[i], tr[i]))
            write_height(9'(tc[i]), 9'(tr[i]), 16'($urandom));
      send_request(CMD_QUERY, col, row, 16'($urandom));
   endtask

   // Settings change only with nothing in flight.
   task automatic apply_settings(bit [9:0] w, bit [9:0] h, bit [23:0] s, bit wc, bit wr);
      req_tvalid <= 0;
      @(posedge clock);
      while (normals.expected_normals.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1;
      csr_addr <= CSR_IMAGE_WIDTH;  csr_wdata <= 24'(w);  @(posedge clock);
      csr_addr <= CSR_IMAGE_HEIGHT; csr_wdata <= 24'(h);  @(posedge clock);
      csr_addr <= CSR_HEIGHT_SCALE; csr_wdata <= s;       @(posedge clock);
      csr_addr <= CSR_WRAP_COLUMNS; csr_wdata <= 24'(wc); @(posedge clock);
      csr_addr <= CSR_WRAP_ROWS;    csr_wdata <= 24'(wr); @(posedge clock);
      csr_we <= 0;
      normals.width_reg = w;
      normals.height_reg = h;
      normals.scale = s;
      normals.wrap_c = wc;
      normals.wrap_r = wr;
   endtask

   // Pick a coordinate, leaning on the image edges and out-of-image values.
   function bit [8:0] pick_pos(int unsigned n);
      case ($urandom_range(0, 5))
         0: return 9'd0;
         1: return 9'(n - 1);
         2: return 9'($urandom_range(0, 511));
         default: return 9'($urandom_range(0, n - 1));
      endcase
   endfunction

   task automatic random_phase(int items);
      int stop;
      stop = sent + items;
      while (sent < stop) begin
         if ($urandom_range(0, 9) < 6)
            query_normal(pick_pos(normals.image_w()), pick_pos(normals.image_h()));
         else
            write_height(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                         16'($urandom));
      end
   endtask

   initial begin
      @(negedge reset);
      @(posedge clock);

      // directed: reset settings, full 512 x 512 image
      write_height(0, 0, 16'hFFFF);
      write_height(1, 0, 16'h0000);
      write_height(0, 1, 16'h0000);
      query_normal(0, 0);                       // steepest one-sided corner
      write_height(511, 511, 16'h0000);
      write_height(510, 511, 16'hFFFF);
      write_height(511, 510, 16'hFFFF);
      query_normal(511, 511);
      write_height(100, 99, 16'h1234);
      write_height(100, 101, 16'h1234);
      write_height(99, 100, 16'h1234);
      write_height(101, 100, 16'h1234);
      query_normal(100, 100);                   // flat: z saturates
      query_normal(511, 0);
      send_request(CMD_QUERY, 511, 511, 16'hFFFF);
      send_request(CMD_QUERY, 0, 0, 16'h0000);

      // out-of-range sizes, widest scale, column wrap
      apply_settings(10'd0, 10'd1023, 24'hFFFFFF, 1, 0);
      query_normal(0, 0);
      query_normal(1, 511);                     // rows held to the last
      query_normal(300, 300);
      random_phase(RANDOM_ITEMS / 5);

      apply_settings(10'd1023, 10'd1, 24'h000000, 0, 1);   // zero scale
      query_normal(511, 0);
      random_phase(RANDOM_ITEMS / 5);

      apply_settings(10'd2, 10'd2, 24'h010000, 1, 1);
      random_phase(RANDOM_ITEMS / 5);

      apply_settings(10'd512, 10'd512, 24'h000100, 1, 1);
      random_phase(RANDOM_ITEMS / 5);

      apply_settings(10'($urandom_range(2, 24)), 10'($urandom_range(2, 24)),
                     24'($urandom_range(0, 24'h40000)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      random_phase(RANDOM_ITEMS / 5);

      req_tvalid <= 0;
      @(posedge clock);
      while (normals.expected_normals.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (normals.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
